>>> hw/rtl/pps_pkg.sv
// Package for the preemptive priority scheduler: sizes, payload structs,
// scheduler state codes and the records passed along the chain of cells.
// No dependencies.
`default_nettype none

package pps_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);

  localparam int ARR_W  = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;
  localparam int PIDX_W = 4;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0]  priority_req;
    logic               last_process;
  } load_item_t;

  typedef struct packed {
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] response;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_response;
    logic              table_overflowed;
    logic              last_result;
  } result_item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_DECIDE,
    S_APPLY,
    S_DRAIN
  } sched_state_t;

  // Selection token that travels one cell per cycle.
  typedef struct packed {
    logic               pick_valid;
    logic [PRIO_W-1:0]  pick_prio;
    logic [IDX_W-1:0]   pick_idx;
    logic [BURST_W-1:0] pick_rem;
    logic               next_valid;
    logic [ARR_W-1:0]   next_arr;
  } tok_t;

  // Per-process record shifted toward cell 0 while results drain.
  typedef struct packed {
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  resp;
    logic [TIME_W-1:0]  comp;
  } rec_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Values broadcast from the controller to every cell.
  typedef struct packed {
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  cur_time;
    logic [BURST_W-1:0] run;
    logic [TIME_W-1:0]  t_new;
  } bcast_t;

endpackage

`default_nettype wire

>>> hw/rtl/pps_cell.sv
// One process slot of the scheduler chain: holds the process state, folds
// itself into the passing selection token and shifts its record on drain.
// Depends on pps_pkg.
`default_nettype none

module pps_cell
  import pps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] idx,
  input  wire cell_ctrl_t       ctrl,
  input  wire bcast_t           bc,
  input  wire tok_t             tok_in,
  output tok_t                  tok_out,
  input  wire rec_t             rec_in,
  output rec_t                  rec_out
);

  logic               occ;
  logic               started;
  logic [ARR_W-1:0]   arr;
  logic [BURST_W-1:0] burst;
  logic [PRIO_W-1:0]  prio;
  logic [BURST_W-1:0] rem;
  logic [TIME_W-1:0]  resp;
  logic [TIME_W-1:0]  comp;

  logic               live;
  logic               arrived;
  logic [TIME_W-1:0]  arr_ext;
  logic [BURST_W-1:0] burst_fix;
  tok_t               tok_next;

  assign arr_ext   = {{(TIME_W-ARR_W){1'b0}}, arr};
  assign live      = occ && (rem != '0);
  assign arrived   = arr_ext <= bc.cur_time;
  assign burst_fix = (bc.burst == '0) ? BURST_W'(1) : bc.burst;

  always_comb begin
    tok_next = tok_in;
    if (live && arrived && (!tok_in.pick_valid || prio < tok_in.pick_prio)) begin
      tok_next.pick_valid = 1'b1;
      tok_next.pick_prio  = prio;
      tok_next.pick_idx   = idx;
      tok_next.pick_rem   = rem;
    end
    if (live && !arrived && (!tok_in.next_valid || arr < tok_in.next_arr)) begin
      tok_next.next_valid = 1'b1;
      tok_next.next_arr   = arr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.pick_valid <= 1'b0;
      tok_out.next_valid <= 1'b0;
    end else begin
      tok_out.pick_valid <= tok_next.pick_valid;
      tok_out.next_valid <= tok_next.next_valid;
    end
    tok_out.pick_prio <= tok_next.pick_prio;
    tok_out.pick_idx  <= tok_next.pick_idx;
    tok_out.pick_rem  <= tok_next.pick_rem;
    tok_out.next_arr  <= tok_next.next_arr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= 1'b0;
      started <= 1'b0;
    end else if (ctrl.clear) begin
      occ     <= 1'b0;
      started <= 1'b0;
    end else if (ctrl.load) begin
      occ     <= 1'b1;
      started <= 1'b0;
    end else if (ctrl.apply) begin
      started <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      arr   <= bc.arr;
      burst <= burst_fix;
      prio  <= bc.prio;
      rem   <= burst_fix;
    end else if (ctrl.apply) begin
      rem <= rem - bc.run;
      if (!started) begin
        resp <= bc.cur_time - arr_ext;
      end
      if (rem == bc.run) begin
        comp <= bc.t_new;
      end
    end else if (ctrl.shift) begin
      arr   <= rec_in.arr;
      burst <= rec_in.burst;
      resp  <= rec_in.resp;
      comp  <= rec_in.comp;
    end
  end

  assign rec_out = '{arr: arr, burst: burst, resp: resp, comp: comp};

endmodule

`default_nettype wire

>>> hw/rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler top level: load port, chain of process
// cells, scheduling controller and result output register.
// Depends on pps_pkg and pps_cell.
//
// Load transactions are taken one per cycle; each fills the next free slot
// of a MAX_PROCESSES-long chain of cells (loads past a full chain are
// dropped and flagged in every result of the run). The transaction marked
// last_process starts a run and holds the load port stalled until the run's
// results are out. Scheduling is event driven: a selection token walks the
// chain one cell per cycle, picking the arrived, unfinished process with the
// smallest priority value (lower slot wins ties) and the earliest pending
// arrival; the controller then advances time to the next completion or
// arrival. One step is the token walk through the cells, a decide state and,
// if a process was picked, an update state, and a run of n processes needs
// at most about 3n steps plus a final walk, independent of the burst
// lengths. Results then leave in load order, one per cycle while
// result_stall is low, as the cell records shift toward slot 0; totals are
// running sums. After the final result enters the output register the
// block clears itself and accepts the next set.
`default_nettype none

module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load_valid,
  output logic              load_stall,
  input  wire load_item_t   load_item,
  output logic              result_valid,
  input  wire logic         result_stall,
  output result_item_t      result_item
);

  sched_state_t state, state_next;

  logic [CNT_W-1:0]   loaded_count;
  logic               overflow;
  logic [TIME_W-1:0]  cur_time;
  logic [BURST_W-1:0] run_reg;
  logic [IDX_W-1:0]   pick_idx;
  logic [IDX_W-1:0]   pass_cnt;
  logic [CNT_W-1:0]   shift_cnt;

  logic [SUM_W-1:0]   turn_sum;
  logic [SUM_W-1:0]   wait_sum;
  logic [SUM_W-1:0]   resp_sum;

  // Drain stage between cell 0 and the output register.
  logic               a_valid;
  logic               a_last;
  logic [PIDX_W-1:0]  a_idx;
  logic [TIME_W-1:0]  a_ct;
  logic [TIME_W-1:0]  a_tat;
  logic [TIME_W-1:0]  a_wt;
  logic [TIME_W-1:0]  a_rt;

  tok_t               tok [MAX_PROCESSES];
  rec_t               rec [MAX_PROCESSES];
  cell_ctrl_t         ctrl [MAX_PROCESSES];
  bcast_t             bc;
  tok_t               seed;
  tok_t               tok_end;

  logic               load_fire;
  logic               pass_done;
  logic               out_load;
  logic               a_load;
  logic               run_done;
  logic [TIME_W-1:0]  t_new;
  logic [TIME_W-1:0]  next_ext;
  logic [TIME_W-1:0]  gap;
  logic [TIME_W-1:0]  rem_ext;
  logic [BURST_W-1:0] run_calc;
  logic [TIME_W-1:0]  tat_calc;
  logic [TIME_W-1:0]  wt_calc;

  assign load_fire = load_valid && !load_stall;
  assign pass_done = pass_cnt == IDX_W'(MAX_PROCESSES - 1);
  assign tok_end   = tok[MAX_PROCESSES-1];
  assign seed      = '0;

  // Output register takes from the drain stage when empty or being drained.
  assign out_load = a_valid && (!result_valid || !result_stall);
  assign a_load   = (state == S_DRAIN) && (shift_cnt < loaded_count)
                    && (!a_valid || out_load);
  assign run_done = (state == S_DRAIN) && out_load && a_last;

  // Step length: up to the chosen process's completion or the next arrival.
  assign next_ext = {{(TIME_W-ARR_W){1'b0}}, tok_end.next_arr};
  assign rem_ext  = {{(TIME_W-BURST_W){1'b0}}, tok_end.pick_rem};
  assign gap      = next_ext - cur_time;
  assign run_calc = (tok_end.next_valid && gap < rem_ext) ? gap[BURST_W-1:0]
                                                          : tok_end.pick_rem;
  assign t_new    = cur_time + {{(TIME_W-BURST_W){1'b0}}, run_reg};

  assign tat_calc = rec[0].comp - {{(TIME_W-ARR_W){1'b0}}, rec[0].arr};
  assign wt_calc  = tat_calc - {{(TIME_W-BURST_W){1'b0}}, rec[0].burst};

  assign bc = '{arr: load_item.arrival_time, burst: load_item.burst_time,
                prio: load_item.priority_req, cur_time: cur_time,
                run: run_reg, t_new: t_new};

  // Chain of cells: token flows upward, records shift downward on drain.
  for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
    tok_t tin;
    rec_t rin;
    if (i == 0) begin : g_head
      assign tin = seed;
    end else begin : g_body
      assign tin = tok[i-1];
    end
    if (i == MAX_PROCESSES - 1) begin : g_tail
      assign rin = rec[i];
    end else begin : g_mid
      assign rin = rec[i+1];
    end

    assign ctrl[i] = '{load:  load_fire && (loaded_count == CNT_W'(i)),
                       apply: (state == S_APPLY) && (pick_idx == IDX_W'(i)),
                       shift: a_load,
                       clear: run_done};

    pps_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(i)),
      .ctrl    (ctrl[i]),
      .bc      (bc),
      .tok_in  (tin),
      .tok_out (tok[i]),
      .rec_in  (rin),
      .rec_out (rec[i])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (load_fire && load_item.last_process) begin
          state_next = S_PASS;
        end
      end
      S_PASS: begin
        if (pass_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (!tok_end.pick_valid && !tok_end.next_valid) begin
          state_next = S_DRAIN;
        end else if (!tok_end.pick_valid) begin
          state_next = S_PASS;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next = S_PASS;
      end
      S_DRAIN: begin
        if (run_done) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    load_stall = 1'b1;
    unique case (state)
      S_LOAD:   load_stall = 1'b0;
      S_PASS,
      S_DECIDE,
      S_APPLY,
      S_DRAIN:  load_stall = 1'b1;
      default:  load_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Load bookkeeping, scheduler time and pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      overflow     <= 1'b0;
      cur_time     <= '0;
      pass_cnt     <= '0;
      shift_cnt    <= '0;
    end else begin
      if (run_done) begin
        loaded_count <= '0;
        overflow     <= 1'b0;
        cur_time     <= '0;
        shift_cnt    <= '0;
      end else begin
        if (load_fire) begin
          if (loaded_count == CNT_W'(MAX_PROCESSES)) begin
            overflow <= 1'b1;
          end else begin
            loaded_count <= loaded_count + CNT_W'(1);
          end
        end
        if (state == S_DECIDE && !tok_end.pick_valid && tok_end.next_valid) begin
          cur_time <= next_ext;
        end else if (state == S_APPLY) begin
          cur_time <= t_new;
        end
        if (a_load) begin
          shift_cnt <= shift_cnt + CNT_W'(1);
        end
      end
      if (state == S_PASS) begin
        pass_cnt <= pass_cnt + IDX_W'(1);
      end else begin
        pass_cnt <= '0;
      end
    end
  end

  // Hold the step decision for the update cycle.
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      run_reg  <= run_calc;
      pick_idx <= tok_end.pick_idx;
    end
  end

  // Drain stage: per-process times from the record in cell 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= 1'b1;
    end else if (out_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_idx  <= shift_cnt[PIDX_W-1:0];
      a_last <= (shift_cnt + CNT_W'(1)) == loaded_count;
      a_ct   <= rec[0].comp;
      a_tat  <= tat_calc;
      a_wt   <= wt_calc;
      a_rt   <= rec[0].resp;
    end
  end

  // Output register and running totals.
  logic [SUM_W-1:0] turn_sum_next;
  logic [SUM_W-1:0] wait_sum_next;
  logic [SUM_W-1:0] resp_sum_next;

  assign turn_sum_next = turn_sum + {{(SUM_W-TIME_W){1'b0}}, a_tat};
  assign wait_sum_next = wait_sum + {{(SUM_W-TIME_W){1'b0}}, a_wt};
  assign resp_sum_next = resp_sum + {{(SUM_W-TIME_W){1'b0}}, a_rt};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      turn_sum     <= '0;
      wait_sum     <= '0;
      resp_sum     <= '0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (run_done) begin
        turn_sum <= '0;
        wait_sum <= '0;
        resp_sum <= '0;
      end else if (out_load) begin
        turn_sum <= turn_sum_next;
        wait_sum <= wait_sum_next;
        resp_sum <= resp_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_item <= '{process_index:    a_idx,
                       completion_time:  a_ct,
                       turnaround:       a_tat,
                       waiting:          a_wt,
                       response:         a_rt,
                       total_turnaround: turn_sum_next,
                       total_waiting:    wait_sum_next,
                       total_response:   resp_sum_next,
                       table_overflowed: overflow,
                       last_result:      a_last};
    end
  end

endmodule

`default_nettype wire
